@@ hdl/bdl_pkg.sv @@
// ----------------------------------------------------------------------------
// bdl_pkg: shared types and constants for the bounded deque list
// Widths, operation and status codes, controller/datapath command and
// status structs, and the ring index helper.
// ----------------------------------------------------------------------------
package bdl_pkg;

    // List capacity; the ring store has one entry per element
    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = CNT_W + 1;

    typedef logic [1:0]        t_func;
    typedef logic [1:0]        t_status;
    typedef logic [DATA_W-1:0] t_data;
    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [1:0]        t_rdsel;

    // Operation codes
    localparam t_func FN_APPEND   = 2'd0;
    localparam t_func FN_POP_HEAD = 2'd1;
    localparam t_func FN_POP_TAIL = 2'd2;
    localparam t_func FN_READ_ALL = 2'd3;

    // Result status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // Read offset select
    localparam t_rdsel RS_HEAD = 2'd0;
    localparam t_rdsel RS_TAIL = 2'd1;
    localparam t_rdsel RS_NEXT = 2'd2;

    localparam t_cnt CNT_FULL = t_cnt'(CAPACITY);
    localparam t_sum SUM_CAP  = t_sum'(CAPACITY);

    // Commands from controller to datapath
    typedef struct packed {
        logic    push;       // write tail entry, grow count
        logic    rd_en;      // issue store read
        t_rdsel  rd_sel;     // which offset to read
        logic    idx_clr;    // restart read-out index
        logic    idx_inc;    // advance read-out index
        logic    load_stat;  // load result with zero value and given status
        t_status stat;
        logic    load_rd;    // load result from store read data
        logic    seq_last;   // last mark follows read-out index
        logic    pop_head;   // drop head element
        logic    pop_tail;   // drop tail element
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic last;          // pending result closes its request
    } t_dp_stat;

    // Ring index: front plus offset, wrapped at capacity (sum < 2*CAPACITY)
    function automatic t_ptr ring_add(input t_ptr front, input t_cnt off);
        t_sum sum;
        sum = t_sum'(front) + t_sum'(off);
        if (sum >= SUM_CAP) begin
            sum = sum - SUM_CAP;
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

@@ hdl/bdl_ram.sv @@
// ----------------------------------------------------------------------------
// bdl_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bdl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/bdl_dp.sv @@
// ----------------------------------------------------------------------------
// bdl_dp: bounded deque list datapath
// Ring pointers, element count, read-out index, element store and the
// result register.
// ----------------------------------------------------------------------------
module bdl_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bdl_pkg::t_cmd    i_cmd,
    input  bdl_pkg::t_data   i_value,
    output bdl_pkg::t_dp_stat o_stat,
    output bdl_pkg::t_data   o_value_res,
    output bdl_pkg::t_status o_status,
    output logic             o_last
);
    import bdl_pkg::*;

    t_ptr    r_front, n_front;
    t_cnt    r_count, n_count;
    t_cnt    r_idx,   n_idx;
    t_data   r_value_res;
    t_status r_status;
    logic    r_last;

    t_cnt    idx_plus;
    t_cnt    rd_off;
    t_ptr    wr_addr;
    t_ptr    rd_addr;
    t_data   rd_data;

    assign idx_plus = r_idx + t_cnt'(1);

    // Pick read offset from the head
    always_comb begin
        case (i_cmd.rd_sel)
            RS_HEAD: rd_off = '0;
            RS_TAIL: rd_off = r_count - t_cnt'(1);
            RS_NEXT: rd_off = idx_plus;
            default: rd_off = '0;
        endcase
    end

    assign wr_addr = ring_add(r_front, r_count);
    assign rd_addr = ring_add(r_front, rd_off);

    bdl_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.push),
        .i_wr_addr(wr_addr),
        .i_wr_data(i_value),
        .i_rd_en  (i_cmd.rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // Advance pointers and count
    always_comb begin
        n_front = r_front;
        n_count = r_count;
        n_idx   = r_idx;
        if (i_cmd.push) begin
            n_count = r_count + t_cnt'(1);
        end
        if (i_cmd.pop_head) begin
            n_front = ring_add(r_front, t_cnt'(1));
            n_count = r_count - t_cnt'(1);
        end
        if (i_cmd.pop_tail) begin
            n_count = r_count - t_cnt'(1);
        end
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = idx_plus;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    // Load result register; hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_stat) begin
            r_value_res <= '0;
            r_status    <= i_cmd.stat;
            r_last      <= 1'b1;
        end else if (i_cmd.load_rd) begin
            r_value_res <= rd_data;
            r_status    <= ST_OK;
            r_last      <= i_cmd.seq_last ? (idx_plus == r_count) : 1'b1;
        end
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.last  = r_last;

    assign o_value_res = r_value_res;
    assign o_status    = r_status;
    assign o_last      = r_last;

endmodule

@@ hdl/bdl_ctrl.sv @@
// ----------------------------------------------------------------------------
// bdl_ctrl: bounded deque list controller
// Takes one request at a time, sequences store reads and result hand-off.
// ----------------------------------------------------------------------------
module bdl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  bdl_pkg::t_func    i_func,
    input  logic              i_stall,
    input  bdl_pkg::t_dp_stat i_stat,
    output logic              o_stall,
    output logic              o_valid,
    output bdl_pkg::t_cmd     o_cmd
);
    import bdl_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state, n_state;
    t_func      r_func,  n_func;

    always_comb begin
        n_state = r_state;
        n_func  = r_func;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_func = i_func;
                    case (i_func)
                        FN_APPEND: begin
                            o_cmd.load_stat = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.stat = ST_FULL;
                            end else begin
                                o_cmd.stat = ST_OK;
                                o_cmd.push = 1'b1;
                            end
                            n_state = S_OUT;
                        end
                        FN_POP_HEAD, FN_POP_TAIL, FN_READ_ALL: begin
                            if (i_stat.empty) begin
                                o_cmd.load_stat = 1'b1;
                                o_cmd.stat      = ST_EMPTY;
                                n_state         = S_OUT;
                            end else begin
                                o_cmd.rd_en   = 1'b1;
                                o_cmd.rd_sel  = (i_func == FN_POP_TAIL) ? RS_TAIL : RS_HEAD;
                                o_cmd.idx_clr = 1'b1;
                                n_state       = S_READ;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                // Store data is ready: load result, drop element on a remove
                o_cmd.load_rd  = 1'b1;
                o_cmd.seq_last = (r_func == FN_READ_ALL);
                o_cmd.pop_head = (r_func == FN_POP_HEAD);
                o_cmd.pop_tail = (r_func == FN_POP_TAIL);
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    if (i_stat.last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.rd_sel  = RS_NEXT;
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_func  <= FN_APPEND;
        end else begin
            r_state <= n_state;
            r_func  <= n_func;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

endmodule

@@ hdl/bounded_deque_list.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_list: bounded double-ended list of signed 32-bit values
// Append, remove head, remove tail and full read-out over a ring store.
//
//   channel  direction  handshake          payload
//   request  in         i_valid / o_stall  i_func, i_value
//   result   out        o_valid / i_stall  o_value_res, o_status, o_last
//
// One request is in flight at a time. Append and any empty/full result are
// valid the cycle after accept; remove is valid once the store read issued on
// accept is registered and loaded into the result (S_READ, then S_OUT).
// Read-out gives one store read per element, each through S_READ and S_OUT.
// Synchronous reset empties the list; no clearing pass is needed.
// A stalled result holds; o_stall stays high until the last result is taken.
// ----------------------------------------------------------------------------
module bounded_deque_list (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  bdl_pkg::t_func   i_func,
    input  bdl_pkg::t_data   i_value,
    output logic             o_valid,
    input  logic             i_stall,
    output bdl_pkg::t_data   o_value_res,
    output bdl_pkg::t_status o_status,
    output logic             o_last
);
    import bdl_pkg::*;

    t_cmd     cmd;
    t_dp_stat dp_stat;

    bdl_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_func (i_func),
        .i_stall(i_stall),
        .i_stat (dp_stat),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .o_cmd  (cmd)
    );

    bdl_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_value    (i_value),
        .o_stat     (dp_stat),
        .o_value_res(o_value_res),
        .o_status   (o_status),
        .o_last     (o_last)
    );

endmodule

@@ hdl/bdl_checker.sv @@
// ----------------------------------------------------------------------------
// bdl_checker: port-level checks for the bounded deque list
// Watches the request and result channels and flags slips over time.
// ----------------------------------------------------------------------------
module bdl_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input bdl_pkg::t_data   o_value_res,
    input bdl_pkg::t_status o_status,
    input logic             o_last
);
    import bdl_pkg::*;

    // Block stays busy while a result is pending
    a_busy_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request taken while a result is pending");

    // An accepted request makes the block busy next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after taking a request");

    // Empty and full results carry zero and close the request
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_value_res == '0 && o_last))
        else $error("empty or full result with data or without last mark");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_value_res)
                                  && $stable(o_status) && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind bounded_deque_list bdl_checker u_chk (.*);

@@ tb/bounded_deque_list_test.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_list_test: self-checking bench for the bounded deque list
// Drives append, remove head, remove tail and read-out requests through
// random gaps and result stalls. Each accepted request is applied to a local
// deque model, and every result that comes out is checked in order.
// ----------------------------------------------------------------------------
module bounded_deque_list_test;

    import bdl_pkg::*;

    localparam int          RANDOM_ITEMS = 250;
    localparam int unsigned CYCLE_LIMIT  = 5_000_000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned HOLD_AFTER   = 30;
    localparam int          DRAIN_CYCLES = 20;

    typedef struct {
        t_func func;
        t_data value;
    } t_list_request;

    typedef struct {
        t_data   value;
        t_status status;
        logic    last;
    } t_list_result;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_valid = 1'b0;
    logic    o_stall;
    t_func   i_func  = FN_APPEND;
    t_data   i_value = '0;
    logic    o_valid;
    logic    i_stall = 1'b0;
    t_data   o_value_res;
    t_status o_status;
    logic    o_last;

    t_list_request pending_requests[$];
    t_list_result  expected_results[$];

    // Deque model state
    t_data       list_store [CAPACITY];
    int unsigned list_head = 0;
    int unsigned list_size = 0;

    // Size the list will have once all planned requests are applied
    int unsigned planned_size = 0;

    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned send_gap      = 0;
    bit          sender_calm   = 1'b0;
    int unsigned stall_left    = 0;
    int unsigned hold_left     = 0;
    bit          hold_done     = 1'b0;
    bit          receiver_calm = 1'b0;
    int unsigned taken_count   = 0;

    bounded_deque_list i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value_res (o_value_res),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    // Apply one request to the deque model and queue the results it causes
    function automatic void apply_list_request(input t_func func, input t_data value);
        t_list_result res;
        res.value  = '0;
        res.status = ST_OK;
        res.last   = 1'b1;
        case (func)
            FN_APPEND: begin
                if (list_size >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    list_store[(list_head + list_size) % CAPACITY] = value;
                    list_size++;
                end
                expected_results.push_back(res);
            end
            FN_POP_HEAD: begin
                if (list_size == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value = list_store[list_head];
                    list_head = (list_head + 1) % CAPACITY;
                    list_size--;
                end
                expected_results.push_back(res);
            end
            FN_POP_TAIL: begin
                if (list_size == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value = list_store[(list_head + list_size - 1) % CAPACITY];
                    list_size--;
                end
                expected_results.push_back(res);
            end
            default: begin
                if (list_size == 0) begin
                    res.status = ST_EMPTY;
                    expected_results.push_back(res);
                end else begin
                    for (int k = 0; k < list_size; k++) begin
                        res.value = list_store[(list_head + k) % CAPACITY];
                        res.last  = (k + 1 == list_size);
                        expected_results.push_back(res);
                    end
                end
            end
        endcase
    endfunction

    // Queue a request for the driver and track the planned list size
    function automatic void plan_request(input t_func func, input t_data value);
        t_list_request req;
        req.func  = func;
        req.value = value;
        pending_requests.push_back(req);
        case (func)
            FN_APPEND: begin
                if (planned_size < CAPACITY) planned_size++;
            end
            FN_POP_HEAD, FN_POP_TAIL: begin
                if (planned_size > 0) planned_size--;
            end
            default: ;
        endcase
    endfunction

    // Mostly random words, with the extremes mixed in
    function automatic t_data pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned idle_cycles(input bit calm);
        int unsigned pick;
        if (calm) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Request driver: predict on accept, then offer the next request after a gap
    always @(posedge i_clk) begin
        t_list_request req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                apply_list_request(i_func, i_value);
                if ($urandom_range(0, 39) == 0) sender_calm = ($urandom_range(0, 2) == 0);
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    req = pending_requests.pop_front();
                    i_valid  <= 1'b1;
                    i_func   <= req.func;
                    i_value  <= req.value;
                    send_gap = idle_cycles(sender_calm);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result stall: random stalls, calm stretches, and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) taken_count++;
            if (!hold_done && taken_count >= HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 199) == 0) receiver_calm = ($urandom_range(0, 2) == 0);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                stall_left = idle_cycles(receiver_calm);
                if (stall_left > 0) begin
                    stall_left--;
                    i_stall <= 1'b1;
                end else begin
                    i_stall <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each taken result with the oldest expectation
    always @(posedge i_clk) begin
        t_list_result exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result: value=%h status=%0d last=%0b",
                         $time, o_value_res, o_status, o_last);
            end else begin
                exp_res = expected_results.pop_front();
                if (o_value_res !== exp_res.value) begin
                    error_count++;
                    $display("%0t: value mismatch: expected %h, actual %h",
                             $time, exp_res.value, o_value_res);
                end
                if (o_status !== exp_res.status) begin
                    error_count++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, exp_res.status, o_status);
                end
                if (o_last !== exp_res.last) begin
                    error_count++;
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, exp_res.last, o_last);
                end
            end
        end
    end

    initial begin
        int unsigned directed_count;
        int unsigned fills_left;
        int unsigned n;
        int unsigned pick;

        // Directed: empty list cases, extremes, one-element tail remove
        plan_request(FN_READ_ALL, 32'h1234_5678);
        plan_request(FN_POP_HEAD, 32'hffff_ffff);
        plan_request(FN_POP_TAIL, 32'h0000_0000);
        plan_request(FN_APPEND, 32'h8000_0000);
        plan_request(FN_APPEND, 32'h7fff_ffff);
        plan_request(FN_APPEND, 32'h0000_0000);
        plan_request(FN_APPEND, 32'hffff_ffff);
        plan_request(FN_READ_ALL, 32'hffff_ffff);
        plan_request(FN_POP_HEAD, 32'h0000_0000);
        plan_request(FN_POP_TAIL, 32'hffff_ffff);
        plan_request(FN_READ_ALL, 32'h0000_0000);
        plan_request(FN_POP_HEAD, 32'h5555_5555);
        plan_request(FN_POP_TAIL, 32'haaaa_aaaa);
        plan_request(FN_APPEND, 32'h5555_5555);
        plan_request(FN_POP_TAIL, 32'h0000_0000);
        plan_request(FN_POP_HEAD, 32'h0000_0000);
        plan_request(FN_READ_ALL, 32'h0000_0000);
        plan_request(FN_APPEND, 32'haaaa_aaaa);
        plan_request(FN_READ_ALL, 32'h5555_5555);
        plan_request(FN_POP_HEAD, 32'h0000_0000);
        directed_count = pending_requests.size();

        // Random: mixed traffic, fills past capacity, drains past empty
        fills_left = 2;
        while (pending_requests.size() < directed_count + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (fills_left == 2 &&
                pending_requests.size() > directed_count + RANDOM_ITEMS / 3) begin
                pick = 0;
            end
            case (pick)
                0: begin
                    if (fills_left > 0) begin
                        n = CAPACITY - planned_size + $urandom_range(1, 3);
                        repeat (n) plan_request(FN_APPEND, pick_value());
                        plan_request(FN_READ_ALL, pick_value());
                        fills_left--;
                    end
                end
                1: begin
                    n = planned_size + 1;
                    repeat (n) begin
                        if ($urandom_range(0, 1)) plan_request(FN_POP_HEAD, pick_value());
                        else plan_request(FN_POP_TAIL, pick_value());
                    end
                end
                2: plan_request(FN_READ_ALL, pick_value());
                default: begin
                    repeat (6) begin
                        n = $urandom_range(0, 9);
                        if (n < 4) plan_request(FN_APPEND, pick_value());
                        else if (n < 6) plan_request(FN_POP_HEAD, pick_value());
                        else if (n < 8) plan_request(FN_POP_TAIL, pick_value());
                        else plan_request(FN_READ_ALL, pick_value());
                    end
                end
            endcase
        end

        // Hold reset, then release it
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to be taken and every result to arrive
        do @(negedge i_clk); while (pending_requests.size() != 0 || i_valid);
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
